### hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Sequencer states, round and start constants and the SHA-256 bit functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  // Sequencer states of the digest engine.
  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StAdd,
    StPad,
    StOut
  } state_e;

  localparam int WordW  = 32;
  localparam int Rounds = 64;
  localparam int LenW   = 61;

  // Round constants.
  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Start values of the hash words.
  localparam logic [31:0] StartH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Pad word for a last word with no valid bytes, and after one that filled all four.
  localparam logic [31:0] PadWord = 32'h80000000;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

### hdl/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
`default_nettype none

// Message word channel.
interface sha256_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source (output valid, output message_word, output valid_bytes,
                  output last_word, input ready);
  modport sink   (input valid, input message_word, input valid_bytes,
                  input last_word, output ready);
endinterface

// Digest word channel.
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_digest_word;

  modport source (output valid, output digest_word, output word_index,
                  output final_digest_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input final_digest_word, output ready);
endinterface

`default_nettype wire

### hdl/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Collects big-endian message words into 64-byte blocks, compresses each
// block with one SHA-256 round per cycle, pads the message on its last word
// and returns the eight digest words.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload
//  --------+-----------+------------------------------------------------
//  in_i    | sink      | message_word[31:0], valid_bytes[2:0], last_word
//  out_o   | source    | digest_word[31:0], word_index[2:0], final_digest_word
//
// A word that completes a block starts a compression: the rounds through the single
// round unit, then one hash update. The last word is followed by the padding words,
// one per cycle, one or two compressions and eight output transactions.
// Input is not ready while a block is compressed, padded or read out; a stalled
// output holds its transaction. Reset loads the start hash and clears the counts.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_digest (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sha256_in_if.sink     in_i,
  sha256_out_if.source  out_o
);

  // Sequencer and control registers.
  sha256_pkg::state_e state_q, state_d;
  logic [3:0]  fill_q, fill_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  idx_q, idx_d;
  logic [sha256_pkg::LenW-1:0] bytes_q, bytes_d;
  logic        pad_q, pad_d;
  logic        need80_q, need80_d;
  logic        len_q, len_d;
  logic        done_q, done_d;
  logic [31:0] hash_q [8];
  logic [31:0] hash_d [8];

  // Payload registers: schedule shift line and working variables.
  logic [31:0] sched_q [16];
  logic [31:0] sched_d [16];
  logic [31:0] var_q [8];
  logic [31:0] var_d [8];

  // Push path into the schedule line.
  logic        push;
  logic [31:0] push_word;
  logic [2:0]  vb_eff;
  logic [31:0] last_word_pad;
  logic        accept_in;
  logic        accept_out;

  // Round unit.
  logic [31:0] t1, t2, ch, maj, w_next;

  assign in_i.ready  = (state_q == sha256_pkg::StIdle);
  assign accept_in   = in_i.valid && in_i.ready;
  assign accept_out  = out_o.valid && out_o.ready;

  assign out_o.valid             = (state_q == sha256_pkg::StOut);
  assign out_o.digest_word       = hash_q[idx_q];
  assign out_o.word_index        = idx_q;
  assign out_o.final_digest_word = (idx_q == 3'd7);

  // Valid byte count on a last word, with counts above four taken as four.
  assign vb_eff = in_i.valid_bytes[2] ? 3'd4 : in_i.valid_bytes;

  // Last word with its trailing bytes replaced by the pad byte and zeros.
  always_comb begin
    case (vb_eff)
      3'd0:    last_word_pad = sha256_pkg::PadWord;
      3'd1:    last_word_pad = {in_i.message_word[31:24], 24'h800000};
      3'd2:    last_word_pad = {in_i.message_word[31:16], 16'h8000};
      3'd3:    last_word_pad = {in_i.message_word[31:8], 8'h80};
      default: last_word_pad = in_i.message_word;
    endcase
  end

  // One compression round and the next schedule word.
  always_comb begin
    ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
    maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
    t1  = var_q[7] + sha256_pkg::big_sigma1(var_q[4]) + ch
        + sha256_pkg::RoundK[round_q] + sched_q[0];
    t2  = sha256_pkg::big_sigma0(var_q[0]) + maj;
    w_next = sched_q[0] + sha256_pkg::small_sigma0(sched_q[1]) + sched_q[9]
           + sha256_pkg::small_sigma1(sched_q[14]);
  end

  // Next state, push selection and register updates.
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    round_d  = round_q;
    idx_d    = idx_q;
    bytes_d  = bytes_q;
    pad_d    = pad_q;
    need80_d = need80_q;
    len_d    = len_q;
    done_d   = done_q;
    hash_d   = hash_q;
    var_d    = var_q;
    sched_d  = sched_q;
    push      = 1'b0;
    push_word = '0;

    case (state_q)
      sha256_pkg::StIdle: begin
        if (accept_in) begin
          push = 1'b1;
          if (!in_i.last_word) begin
            push_word = in_i.message_word;
            bytes_d   = bytes_q + sha256_pkg::LenW'(4);
            if (fill_q == 4'd15) begin
              state_d = sha256_pkg::StRound;
            end
          end else begin
            push_word = last_word_pad;
            bytes_d   = bytes_q + {58'b0, vb_eff};
            pad_d     = 1'b1;
            need80_d  = (vb_eff == 3'd4);
            state_d   = (fill_q == 4'd15) ? sha256_pkg::StRound : sha256_pkg::StPad;
          end
        end
      end

      sha256_pkg::StPad: begin
        push = 1'b1;
        if (need80_q) begin
          push_word = sha256_pkg::PadWord;
          need80_d  = 1'b0;
        end else if (fill_q == 4'd14) begin
          push_word = bytes_q[60:29];
          len_d     = 1'b1;
        end else if (fill_q == 4'd15 && len_q) begin
          push_word = {bytes_q[28:0], 3'b000};
          done_d    = 1'b1;
        end else begin
          push_word = '0;
        end
        if (fill_q == 4'd15) begin
          state_d = sha256_pkg::StRound;
        end
      end

      sha256_pkg::StRound: begin
        var_d[7] = var_q[6];
        var_d[6] = var_q[5];
        var_d[5] = var_q[4];
        var_d[4] = var_q[3] + t1;
        var_d[3] = var_q[2];
        var_d[2] = var_q[1];
        var_d[1] = var_q[0];
        var_d[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          sched_d[i] = sched_q[i+1];
        end
        sched_d[15] = w_next;
        round_d = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = sha256_pkg::StAdd;
        end
      end

      sha256_pkg::StAdd: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + var_q[i];
        end
        if (done_q) begin
          state_d = sha256_pkg::StOut;
          idx_d   = 3'd0;
        end else if (pad_q) begin
          state_d = sha256_pkg::StPad;
        end else begin
          state_d = sha256_pkg::StIdle;
        end
      end

      sha256_pkg::StOut: begin
        if (accept_out) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_d  = sha256_pkg::StIdle;
            hash_d   = sha256_pkg::StartH;
            bytes_d  = '0;
            pad_d    = 1'b0;
            need80_d = 1'b0;
            len_d    = 1'b0;
            done_d   = 1'b0;
          end
        end
      end

      default: begin
        state_d = sha256_pkg::StIdle;
      end
    endcase

    // Shift a pushed word into the block buffer.
    if (push) begin
      for (int i = 0; i < 15; i++) begin
        sched_d[i] = sched_q[i+1];
      end
      sched_d[15] = push_word;
      fill_d = fill_q + 4'd1;
    end

    // Load the working variables when a compression starts.
    if (state_d == sha256_pkg::StRound && state_q != sha256_pkg::StRound) begin
      var_d   = hash_q;
      round_d = 6'd0;
    end
  end

  // Control state and hash words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha256_pkg::StIdle;
      fill_q   <= '0;
      round_q  <= '0;
      idx_q    <= '0;
      bytes_q  <= '0;
      pad_q    <= 1'b0;
      need80_q <= 1'b0;
      len_q    <= 1'b0;
      done_q   <= 1'b0;
      hash_q   <= sha256_pkg::StartH;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      round_q  <= round_d;
      idx_q    <= idx_d;
      bytes_q  <= bytes_d;
      pad_q    <= pad_d;
      need80_q <= need80_d;
      len_q    <= len_d;
      done_q   <= done_d;
      hash_q   <= hash_d;
    end
  end

  // Block buffer and working variables carry no reset.
  always_ff @(posedge clk_i) begin
    sched_q <= sched_d;
    var_q   <= var_d;
  end

endmodule

`default_nettype wire
